// ===== rtl/core/pjhr_pkg.sv =====
// ----------------------------------------------------------------------------
// pjhr_pkg: shared types and constants of the packet hold-and-release block
// Configuration layout, command words between front and back, state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pjhr_pkg;

  localparam int unsigned IDENT_W    = 32;
  localparam int unsigned NUMBER_W   = 32;
  localparam int unsigned DRAW_W     = 31;
  localparam int unsigned INTERVAL_W = 15;
  localparam int unsigned BURST_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned VERDICT_W  = 2;

  // Number of restoring steps for a remainder of a draw word.
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned STEP_W     = 5;

  // Largest burst target that the position counter can hold.
  localparam int unsigned TARGET_MAX = 31;

  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_PTR_W    = 1;
  localparam int unsigned Q_CNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BURST_INTERVAL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BURST           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_INTERVAL_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LENGTH_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_RELEASE     = 3'd4;

  localparam logic [INTERVAL_W-1:0] RST_BURST_INTERVAL = 15'd100;
  localparam logic [BURST_W-1:0]    RST_MAX_BURST      = 5'd4;

  localparam logic [VERDICT_W-1:0] VERDICT_PASS    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_HOLD    = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACTIVE,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_HOLD,
    CMD_RELEASE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PASS,
    B_HOLD,
    B_REL,
    B_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] burst_interval;
    logic [BURST_W-1:0]    max_burst;
    logic                  fixed_interval_mode;
    logic                  fixed_length_mode;
    logic                  reverse_release;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [IDENT_W-1:0]   ident;
    logic [BURST_W-1:0]   pos;
    logic                 reverse;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pjhr_ram.sv =====
// ----------------------------------------------------------------------------
// pjhr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pjhr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/pjhr_front.sv =====
// ----------------------------------------------------------------------------
// pjhr_front: word intake and burst classification
// Takes remainders of the draw words bit-serially, tracks the burst phase and
// turns each word into one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pjhr_front #(
  parameter int unsigned HOLD_DEPTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire logic [pjhr_pkg::IDENT_W-1:0]     packet_ident,
  input  wire logic [pjhr_pkg::NUMBER_W-1:0]    packet_number,
  input  wire logic [pjhr_pkg::DRAW_W-1:0]      trigger_draw,
  input  wire logic [pjhr_pkg::DRAW_W-1:0]      length_draw,
  input  wire pjhr_pkg::cfg_t                   cfg,
  input  wire pjhr_pkg::q_status_t              q_status,
  output logic                                  busy,
  output logic                                  push,
  output pjhr_pkg::cmd_t                        cmd
);

  localparam int unsigned LIM_I =
    (HOLD_DEPTH - 1 < pjhr_pkg::TARGET_MAX) ? HOLD_DEPTH - 1 : pjhr_pkg::TARGET_MAX;
  localparam logic [pjhr_pkg::BURST_W:0] LIM = (pjhr_pkg::BURST_W + 1)'(LIM_I);

  pjhr_pkg::front_state_t state_r, state_nxt;
  pjhr_pkg::phase_t       phase_r, phase_nxt;
  logic [pjhr_pkg::BURST_W-1:0]    hold_pos_r, hold_pos_nxt;
  logic [pjhr_pkg::BURST_W-1:0]    target_r, target_nxt;
  logic [pjhr_pkg::NUMBER_W-1:0]   end_count_r, end_count_nxt;
  logic [pjhr_pkg::IDENT_W-1:0]    ident_r, ident_nxt;
  logic [pjhr_pkg::NUMBER_W-1:0]   number_r, number_nxt;
  logic [pjhr_pkg::DRAW_W-1:0]     tdiv_r, tdiv_nxt;
  logic [pjhr_pkg::DRAW_W-1:0]     ldiv_r, ldiv_nxt;
  logic [pjhr_pkg::INTERVAL_W-1:0] trem_r, trem_nxt;
  logic [pjhr_pkg::BURST_W-1:0]    lrem_r, lrem_nxt;
  logic [pjhr_pkg::STEP_W-1:0]     step_r, step_nxt;

  logic [pjhr_pkg::INTERVAL_W:0]   t_shift;
  logic [pjhr_pkg::INTERVAL_W:0]   t_step;
  logic [pjhr_pkg::BURST_W:0]      l_shift;
  logic [pjhr_pkg::BURST_W:0]      l_step;
  logic [pjhr_pkg::NUMBER_W-1:0]   gap;
  logic                            fire;
  logic [pjhr_pkg::BURST_W:0]      raw_target;
  logic [pjhr_pkg::BURST_W-1:0]    new_target;

  // One restoring step per cycle for both remainders.
  always_comb begin
    t_shift = {trem_r, tdiv_r[pjhr_pkg::DRAW_W-1]};
    if (t_shift >= {1'b0, cfg.burst_interval}) begin
      t_step = t_shift - {1'b0, cfg.burst_interval};
    end else begin
      t_step = t_shift;
    end
    l_shift = {lrem_r, ldiv_r[pjhr_pkg::DRAW_W-1]};
    if (l_shift >= {1'b0, cfg.max_burst}) begin
      l_step = l_shift - {1'b0, cfg.max_burst};
    end else begin
      l_step = l_shift;
    end
  end

  always_comb begin
    gap = number_r - end_count_r;
    if (cfg.fixed_interval_mode) begin
      fire = gap >= {{(pjhr_pkg::NUMBER_W - pjhr_pkg::INTERVAL_W){1'b0}}, cfg.burst_interval};
    end else begin
      fire = (cfg.burst_interval == '0) || (trem_r == '0);
    end
    if (cfg.fixed_length_mode) begin
      raw_target = {1'b0, cfg.max_burst};
    end else if (cfg.max_burst == '0) begin
      raw_target = (pjhr_pkg::BURST_W + 1)'(1);
    end else begin
      raw_target = {1'b0, lrem_r} + (pjhr_pkg::BURST_W + 1)'(1);
    end
    if (raw_target > LIM) begin
      new_target = LIM[pjhr_pkg::BURST_W-1:0];
    end else begin
      new_target = raw_target[pjhr_pkg::BURST_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pjhr_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = (phase_r == pjhr_pkg::PH_IDLE) ? pjhr_pkg::F_DIV : pjhr_pkg::F_PUSH;
        end
      end
      pjhr_pkg::F_DIV: begin
        if (step_r == pjhr_pkg::STEP_W'(pjhr_pkg::DIV_STEPS - 1)) begin
          state_nxt = pjhr_pkg::F_PUSH;
        end
      end
      pjhr_pkg::F_PUSH: begin
        if (!q_status.full) begin
          state_nxt = pjhr_pkg::F_IDLE;
        end
      end
      default: state_nxt = pjhr_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    push          = 1'b0;
    cmd.kind      = pjhr_pkg::CMD_PASS;
    cmd.ident     = ident_r;
    cmd.pos       = hold_pos_r;
    cmd.reverse   = cfg.reverse_release;
    phase_nxt     = phase_r;
    hold_pos_nxt  = hold_pos_r;
    target_nxt    = target_r;
    end_count_nxt = end_count_r;
    ident_nxt     = ident_r;
    number_nxt    = number_r;
    tdiv_nxt      = tdiv_r;
    ldiv_nxt      = ldiv_r;
    trem_nxt      = trem_r;
    lrem_nxt      = lrem_r;
    step_nxt      = step_r;
    case (state_r)
      pjhr_pkg::F_IDLE: begin
        if (accept) begin
          ident_nxt  = packet_ident;
          number_nxt = packet_number;
          tdiv_nxt   = trigger_draw;
          ldiv_nxt   = length_draw;
          trem_nxt   = '0;
          lrem_nxt   = '0;
          step_nxt   = '0;
        end
      end
      pjhr_pkg::F_DIV: begin
        tdiv_nxt = {tdiv_r[pjhr_pkg::DRAW_W-2:0], 1'b0};
        ldiv_nxt = {ldiv_r[pjhr_pkg::DRAW_W-2:0], 1'b0};
        trem_nxt = t_step[pjhr_pkg::INTERVAL_W-1:0];
        lrem_nxt = l_step[pjhr_pkg::BURST_W-1:0];
        step_nxt = step_r + pjhr_pkg::STEP_W'(1);
      end
      pjhr_pkg::F_PUSH: begin
        case (phase_r)
          pjhr_pkg::PH_IDLE: begin
            if (fire) begin
              cmd.kind   = pjhr_pkg::CMD_HOLD;
              cmd.pos    = '0;
              target_nxt = new_target;
              if (new_target == '0) begin
                hold_pos_nxt  = '0;
                end_count_nxt = number_r;
                phase_nxt     = pjhr_pkg::PH_STOP;
              end else begin
                hold_pos_nxt = pjhr_pkg::BURST_W'(1);
                phase_nxt    = pjhr_pkg::PH_ACTIVE;
              end
            end
          end
          pjhr_pkg::PH_ACTIVE: begin
            cmd.kind = pjhr_pkg::CMD_HOLD;
            if (hold_pos_r >= target_r) begin
              end_count_nxt = number_r;
              phase_nxt     = pjhr_pkg::PH_STOP;
            end else begin
              hold_pos_nxt = hold_pos_r + pjhr_pkg::BURST_W'(1);
            end
          end
          pjhr_pkg::PH_STOP: begin
            cmd.kind  = pjhr_pkg::CMD_RELEASE;
            phase_nxt = pjhr_pkg::PH_IDLE;
          end
          default: phase_nxt = pjhr_pkg::PH_IDLE;
        endcase
        if (q_status.full) begin
          phase_nxt     = phase_r;
          hold_pos_nxt  = hold_pos_r;
          target_nxt    = target_r;
          end_count_nxt = end_count_r;
        end else begin
          push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pjhr_pkg::F_IDLE;
      phase_r     <= pjhr_pkg::PH_IDLE;
      hold_pos_r  <= '0;
      target_r    <= '0;
      end_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hold_pos_r  <= hold_pos_nxt;
      target_r    <= target_nxt;
      end_count_r <= end_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ident_r  <= ident_nxt;
    number_r <= number_nxt;
    tdiv_r   <= tdiv_nxt;
    ldiv_r   <= ldiv_nxt;
    trem_r   <= trem_nxt;
    lrem_r   <= lrem_nxt;
    step_r   <= step_nxt;
  end

  assign busy = (state_r != pjhr_pkg::F_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/pjhr_queue.sv =====
// ----------------------------------------------------------------------------
// pjhr_queue: short command queue between front and back
// Two entries, first in first out.
// ----------------------------------------------------------------------------
`default_nettype none

module pjhr_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire pjhr_pkg::cmd_t      push_cmd,
  input  wire logic                pop,
  output pjhr_pkg::cmd_t           pop_cmd,
  output pjhr_pkg::q_status_t      status
);

  pjhr_pkg::cmd_t mem_r [pjhr_pkg::Q_DEPTH];
  logic [pjhr_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pjhr_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pjhr_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  always_comb begin
    status.empty = (count_r == '0);
    status.full  = (count_r == pjhr_pkg::Q_CNT_W'(pjhr_pkg::Q_DEPTH));
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    wr_ptr_nxt   = do_push ? wr_ptr_r + pjhr_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt   = do_pop ? rd_ptr_r + pjhr_pkg::Q_PTR_W'(1) : rd_ptr_r;
    count_nxt    = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + pjhr_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - pjhr_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/core/pjhr_back.sv =====
// ----------------------------------------------------------------------------
// pjhr_back: command execution and result generation
// Stores held identifiers, plays them back on release and emits the words.
// ----------------------------------------------------------------------------
`default_nettype none

module pjhr_back #(
  parameter int unsigned HOLD_DEPTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pjhr_pkg::q_status_t              q_status,
  input  wire pjhr_pkg::cmd_t                   q_cmd,
  output logic                                  pop,
  output logic                                  busy,
  output logic                                  out_strobe,
  output logic [pjhr_pkg::IDENT_W-1:0]          out_ident,
  output logic [pjhr_pkg::VERDICT_W-1:0]        out_verdict,
  output logic                                  out_last_of_run
);

  localparam int unsigned AW = $clog2(HOLD_DEPTH);

  pjhr_pkg::back_state_t        state_r, state_nxt;
  pjhr_pkg::cmd_t               cmd_r;
  logic [pjhr_pkg::BURST_W-1:0] idx_r;
  logic                         rd_pend_r;
  logic [pjhr_pkg::BURST_W-1:0] rd_pos;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [pjhr_pkg::IDENT_W-1:0] ram_rdata;

  pjhr_ram #(
    .WIDTH (pjhr_pkg::IDENT_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd_r.ident),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pjhr_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          case (q_cmd.kind)
            pjhr_pkg::CMD_PASS:    state_nxt = pjhr_pkg::B_PASS;
            pjhr_pkg::CMD_HOLD:    state_nxt = pjhr_pkg::B_HOLD;
            pjhr_pkg::CMD_RELEASE: state_nxt = pjhr_pkg::B_REL;
            default:               state_nxt = pjhr_pkg::B_IDLE;
          endcase
        end
      end
      pjhr_pkg::B_PASS:  state_nxt = pjhr_pkg::B_IDLE;
      pjhr_pkg::B_HOLD:  state_nxt = pjhr_pkg::B_IDLE;
      pjhr_pkg::B_REL: begin
        if (idx_r == cmd_r.pos) begin
          state_nxt = pjhr_pkg::B_DRAIN;
        end
      end
      pjhr_pkg::B_DRAIN: state_nxt = pjhr_pkg::B_PASS;
      default:           state_nxt = pjhr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state_r == pjhr_pkg::B_IDLE) && !q_status.empty;
    busy      = (state_r != pjhr_pkg::B_IDLE);
    rd_pos    = cmd_r.reverse ? cmd_r.pos - idx_r : idx_r;
    ram_raddr = AW'(rd_pos);
    ram_we    = (state_r == pjhr_pkg::B_HOLD);
    ram_waddr = AW'(cmd_r.pos);
    out_strobe = rd_pend_r || (state_r == pjhr_pkg::B_PASS) || (state_r == pjhr_pkg::B_HOLD);
    out_last_of_run = !rd_pend_r;
    if (rd_pend_r) begin
      out_ident   = ram_rdata;
      out_verdict = pjhr_pkg::VERDICT_RELEASE;
    end else begin
      out_ident   = cmd_r.ident;
      out_verdict = (state_r == pjhr_pkg::B_HOLD) ? pjhr_pkg::VERDICT_HOLD
                                                   : pjhr_pkg::VERDICT_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pjhr_pkg::B_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == pjhr_pkg::B_REL);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_cmd;
      idx_r <= '0;
    end else if (state_r == pjhr_pkg::B_REL) begin
      idx_r <= idx_r + pjhr_pkg::BURST_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/packet_jitter_hold_and_release.sv =====
// ----------------------------------------------------------------------------
// packet_jitter_hold_and_release: burst hold-and-release impairment
// Holds bursts of packet descriptors and releases them in one run.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// every result of that word has been shown. Results appear on out_strobe for
// one cycle each and cannot be held off. While no burst is running, a word
// goes through the 31-step bit-serial remainder unit that evaluates the
// trigger and length draws before its command is queued; during a burst
// that unit is skipped. The releasing word gives one result per cycle from
// the hold memory's registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_jitter_hold_and_release #(
  parameter int unsigned HOLD_DEPTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [pjhr_pkg::IDENT_W-1:0]       in_packet_ident,
  input  wire logic [pjhr_pkg::NUMBER_W-1:0]      in_packet_number,
  input  wire logic [pjhr_pkg::DRAW_W-1:0]        in_trigger_draw,
  input  wire logic [pjhr_pkg::DRAW_W-1:0]        in_length_draw,
  output logic                                    out_strobe,
  output logic [pjhr_pkg::IDENT_W-1:0]            out_ident,
  output logic [pjhr_pkg::VERDICT_W-1:0]          out_verdict,
  output logic                                    out_last_of_run,
  input  wire logic                               cfg_we,
  input  wire logic [pjhr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pjhr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  pjhr_pkg::cfg_t      cfg_r, cfg_nxt;
  pjhr_pkg::q_status_t q_status;
  pjhr_pkg::cmd_t      push_cmd;
  pjhr_pkg::cmd_t      pop_cmd;
  logic                accept;
  logic                front_busy;
  logic                back_busy;
  logic                push;
  logic                pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pjhr_pkg::REG_BURST_INTERVAL:
          cfg_nxt.burst_interval = cfg_wdata[pjhr_pkg::INTERVAL_W-1:0];
        pjhr_pkg::REG_MAX_BURST:
          cfg_nxt.max_burst = cfg_wdata[pjhr_pkg::BURST_W-1:0];
        pjhr_pkg::REG_FIXED_INTERVAL_MODE:
          cfg_nxt.fixed_interval_mode = cfg_wdata[0];
        pjhr_pkg::REG_FIXED_LENGTH_MODE:
          cfg_nxt.fixed_length_mode = cfg_wdata[0];
        pjhr_pkg::REG_REVERSE_RELEASE:
          cfg_nxt.reverse_release = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burst_interval      <= pjhr_pkg::RST_BURST_INTERVAL;
      cfg_r.max_burst           <= pjhr_pkg::RST_MAX_BURST;
      cfg_r.fixed_interval_mode <= 1'b0;
      cfg_r.fixed_length_mode   <= 1'b0;
      cfg_r.reverse_release     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign busy   = front_busy || back_busy || !q_status.empty;
  assign accept = start && !busy;

  pjhr_front #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .packet_ident  (in_packet_ident),
    .packet_number (in_packet_number),
    .trigger_draw  (in_trigger_draw),
    .length_draw   (in_length_draw),
    .cfg           (cfg_r),
    .q_status      (q_status),
    .busy          (front_busy),
    .push          (push),
    .cmd           (push_cmd)
  );

  pjhr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  pjhr_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .q_cmd           (pop_cmd),
    .pop             (pop),
    .busy            (back_busy),
    .out_strobe      (out_strobe),
    .out_ident       (out_ident),
    .out_verdict     (out_verdict),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pjhr_checker.sv =====
// ----------------------------------------------------------------------------
// pjhr_checker: port-level checks of the hold-and-release block
// Watches the handshake and result ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pjhr_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              out_strobe,
  input wire logic [pjhr_pkg::VERDICT_W-1:0]    out_verdict,
  input wire logic                              out_last_of_run
);

  // A result only appears while the word that caused it is still in work.
  a_strobe_while_busy: assert property (
    @(posedge clk) disable iff (!rst_n) out_strobe |-> busy
  ) else $error("result shown while block is not busy");

  a_accept_sets_busy: assert property (
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy
  ) else $error("busy not raised after an accepted word");

  a_verdict_code: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_strobe |-> (out_verdict == pjhr_pkg::VERDICT_PASS ||
                      out_verdict == pjhr_pkg::VERDICT_HOLD ||
                      out_verdict == pjhr_pkg::VERDICT_RELEASE)
  ) else $error("undefined verdict code");

  // A released packet is never the final result; the run continues next cycle.
  a_release_not_last: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_strobe && out_verdict == pjhr_pkg::VERDICT_RELEASE) |-> !out_last_of_run
  ) else $error("released packet marked as final result");

  a_release_run_continues: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_strobe && out_verdict == pjhr_pkg::VERDICT_RELEASE) |=> out_strobe
  ) else $error("release run broken before its closing result");

endmodule

bind packet_jitter_hold_and_release pjhr_checker u_pjhr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_verdict     (out_verdict),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire

// ===== test/packet_jitter_hold_and_release_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_jitter_hold_and_release_tb: self-checking bench of the burst hold block
// A queued driver feeds packet descriptors through the start/busy handshake
// while a monitor checks every result word against an in-bench prediction of
// the hold, release and pass decisions, over several register settings.
// ----------------------------------------------------------------------------
module packet_jitter_hold_and_release_tb;
  import pjhr_pkg::*;

  localparam int unsigned HOLD_DEPTH  = 32;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct {
    logic [IDENT_W-1:0]  ident;
    logic [NUMBER_W-1:0] number;
    logic [DRAW_W-1:0]   trigger_draw;
    logic [DRAW_W-1:0]   length_draw;
  } packet_t;

  typedef struct {
    logic [IDENT_W-1:0]   ident;
    logic [VERDICT_W-1:0] verdict;
    logic                 last_of_run;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [IDENT_W-1:0]    in_packet_ident = '0;
  logic [NUMBER_W-1:0]   in_packet_number = '0;
  logic [DRAW_W-1:0]     in_trigger_draw = '0;
  logic [DRAW_W-1:0]     in_length_draw = '0;
  logic                  out_strobe;
  logic [IDENT_W-1:0]    out_ident;
  logic [VERDICT_W-1:0]  out_verdict;
  logic                  out_last_of_run;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  packet_t     pending_packets[$];
  outcome_t    expected_outcomes[$];
  packet_t     on_port;
  int unsigned send_idle_pct = 10;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic [NUMBER_W-1:0] running_number = '0;

  // Predicted state of the block and its registers.
  cfg_t                live_cfg = '{burst_interval: RST_BURST_INTERVAL,
                                    max_burst: RST_MAX_BURST, default: 1'b0};
  phase_t              burst_phase = PH_IDLE;
  int unsigned         hold_pos = 0;
  int unsigned         burst_target = 0;
  logic [NUMBER_W-1:0] burst_end_count = '0;
  logic [IDENT_W-1:0]  held_store[HOLD_DEPTH];

  packet_jitter_hold_and_release #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_packet_ident (in_packet_ident),
    .in_packet_number(in_packet_number),
    .in_trigger_draw (in_trigger_draw),
    .in_length_draw  (in_length_draw),
    .out_strobe      (out_strobe),
    .out_ident       (out_ident),
    .out_verdict     (out_verdict),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic expect_outcome(input logic [IDENT_W-1:0] ident,
                                input logic [VERDICT_W-1:0] verdict, input logic last);
    outcome_t o;
    o.ident = ident;
    o.verdict = verdict;
    o.last_of_run = last;
    expected_outcomes.push_back(o);
  endtask

  task automatic predict_hold_release(input packet_t p);
    logic        fire;
    int unsigned tgt;
    int unsigned lim;
    int unsigned cnt;
    int unsigned slot;
    if (burst_phase == PH_IDLE) begin
      if (live_cfg.fixed_interval_mode) begin
        fire = (p.number - burst_end_count) >= {17'd0, live_cfg.burst_interval};
      end else if (live_cfg.burst_interval == '0) begin
        fire = 1'b1;
      end else begin
        fire = (p.trigger_draw % live_cfg.burst_interval) == 0;
      end
      if (!fire) begin
        expect_outcome(p.ident, VERDICT_PASS, 1'b1);
        return;
      end
      hold_pos = 0;
      if (live_cfg.fixed_length_mode) begin
        tgt = live_cfg.max_burst;
      end else if (live_cfg.max_burst == '0) begin
        tgt = 1;
      end else begin
        tgt = (p.length_draw % live_cfg.max_burst) + 1;
      end
      lim = (HOLD_DEPTH - 1 < TARGET_MAX) ? HOLD_DEPTH - 1 : TARGET_MAX;
      burst_target = (tgt > lim) ? lim : tgt;
      burst_phase = PH_ACTIVE;
    end
    if (burst_phase == PH_ACTIVE) begin
      slot = (hold_pos < HOLD_DEPTH) ? hold_pos : HOLD_DEPTH - 1;
      held_store[slot] = p.ident;
      if (hold_pos >= burst_target) begin
        burst_end_count = p.number;
        burst_phase = PH_STOP;
      end else begin
        hold_pos++;
      end
      expect_outcome(p.ident, VERDICT_HOLD, 1'b1);
      return;
    end
    cnt = (hold_pos + 1 > HOLD_DEPTH) ? HOLD_DEPTH : hold_pos + 1;
    for (int unsigned i = 0; i < cnt; i++) begin
      expect_outcome(held_store[live_cfg.reverse_release ? cnt - 1 - i : i],
                     VERDICT_RELEASE, 1'b0);
    end
    expect_outcome(p.ident, VERDICT_PASS, 1'b1);
    burst_phase = PH_IDLE;
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // The driver presents the next queued word when the port is free, except on randomly chosen idle cycles.
  always @(posedge clk) begin : drive_words
    if (rst_n) begin
      if (start && !busy) begin
        predict_hold_release(on_port);
      end
      if (start && busy) begin
      end else if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_port = pending_packets.pop_front();
        start <= 1'b1;
        in_packet_ident <= on_port.ident;
        in_packet_number <= on_port.number;
        in_trigger_draw <= on_port.trigger_draw;
        in_length_draw <= on_port.length_draw;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_words
    outcome_t want;
    if (rst_n && out_strobe) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected word, ident %h verdict %0d",
                                  out_ident, out_verdict));
      end else begin
        want = expected_outcomes.pop_front();
        if (out_ident !== want.ident)
          report_mismatch($sformatf("ident %h, predicted %h", out_ident, want.ident));
        if (out_verdict !== want.verdict)
          report_mismatch($sformatf("verdict %0d, predicted %0d for ident %h",
                                    out_verdict, want.verdict, want.ident));
        if (out_last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, predicted %b for ident %h",
                                    out_last_of_run, want.last_of_run, want.ident));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_BURST_INTERVAL:      live_cfg.burst_interval = data[INTERVAL_W-1:0];
      REG_MAX_BURST:           live_cfg.max_burst = data[BURST_W-1:0];
      REG_FIXED_INTERVAL_MODE: live_cfg.fixed_interval_mode = data[0];
      REG_FIXED_LENGTH_MODE:   live_cfg.fixed_length_mode = data[0];
      REG_REVERSE_RELEASE:     live_cfg.reverse_release = data[0];
      default: ;
    endcase
  endtask

  task automatic program_settings(input int unsigned interval, input int unsigned burst,
                                  input logic by_count, input logic fixed_len,
                                  input logic reversed);
    write_reg(REG_BURST_INTERVAL, CFG_DATA_W'(interval));
    write_reg(REG_MAX_BURST, CFG_DATA_W'(burst));
    write_reg(REG_FIXED_INTERVAL_MODE, CFG_DATA_W'(by_count));
    write_reg(REG_FIXED_LENGTH_MODE, CFG_DATA_W'(fixed_len));
    write_reg(REG_REVERSE_RELEASE, CFG_DATA_W'(reversed));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_for_quiet();
    while (pending_packets.size() != 0 || start || expected_outcomes.size() != 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_packet(input logic [IDENT_W-1:0] ident,
                              input logic [NUMBER_W-1:0] number,
                              input logic [DRAW_W-1:0] tdraw, input logic [DRAW_W-1:0] ldraw);
    packet_t p;
    p.ident = ident;
    p.number = number;
    p.trigger_draw = tdraw;
    p.length_draw = ldraw;
    pending_packets.push_back(p);
  endtask

  function automatic logic [DRAW_W-1:0] random_draw();
    logic [31:0] w;
    w = $urandom();
    return w[DRAW_W-1:0];
  endfunction

  // Mostly well-formed traffic: counts that advance by one or by a whole
  // interval, and, outside fixed-interval mode, some trigger words that are exact multiples of the interval.
  task automatic queue_random_packets(input int unsigned count);
    logic [DRAW_W-1:0] tdraw;
    longint unsigned   span;
    int unsigned       pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 6)
        running_number = $urandom();
      else if (pick < 16)
        running_number = running_number + live_cfg.burst_interval;
      else
        running_number = running_number + 1;
      tdraw = random_draw();
      if (!live_cfg.fixed_interval_mode && live_cfg.burst_interval != '0 &&
          $urandom_range(99) < 35) begin
        span = 64'h7FFF_FFFF / live_cfg.burst_interval;
        tdraw = DRAW_W'(longint'($urandom_range(32'(span), 0)) * live_cfg.burst_interval);
      end
      queue_packet($urandom(), running_number, tdraw, random_draw());
    end
  endtask

  initial begin : run_test
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a non-multiple passes, a zero trigger word starts a
    // burst whose length comes from the all-ones length word.
    send_idle_pct = 10;
    queue_packet(32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0000);
    queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0000, 31'h7FFF_FFFF);
    queue_packet(32'hA5A5_5A5A, 32'h0000_0001, 31'h1234_5678, 31'h0765_4321);
    queue_packet(32'h5A5A_A5A5, 32'h0000_0002, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_packet(32'h0123_4567, 32'h0000_0003, 31'h0000_0000, 31'h0000_0000);
    queue_packet(32'h89AB_CDEF, 32'h0000_0004, 31'h5555_5555, 31'h2AAA_AAAA);
    queue_packet(32'hFEDC_BA98, 32'h8000_0000, 31'h7FFF_FFFF, 31'h0000_0001);
    wait_for_quiet();

    // Zero interval with zero fixed length: a single word held, released newest first.
    program_settings(0, 0, 1'b0, 1'b1, 1'b1);
    queue_packet(32'h1111_1111, 32'h0000_0010, 31'h0000_3039, 31'h0000_0000);
    queue_packet(32'h2222_2222, 32'h0000_0011, 31'h0000_0007, 31'h0000_0000);
    wait_for_quiet();

    // Count trigger with zero interval and random length with zero bound.
    program_settings(0, 0, 1'b1, 1'b0, 1'b0);
    queue_packet(32'h3333_3333, 32'h0000_0000, 31'h0000_0000, 31'h7FFF_FFFF);
    queue_packet(32'h4444_4444, 32'h0000_0001, 31'h0000_0001, 31'h0000_0002);
    queue_packet(32'h5555_5555, 32'h0000_0002, 31'h0000_0002, 31'h0000_0003);
    wait_for_quiet();

    // Longest bursts, released newest first.
    program_settings(3, 31, 1'b1, 1'b1, 1'b1);
    queue_random_packets(60);
    wait_for_quiet();

    program_settings(7, 5, 1'b0, 1'b0, 1'b0);
    queue_random_packets(80);
    wait_for_quiet();

    send_idle_pct = 58;
    program_settings(32767, 1, 1'b0, 1'b0, 1'b1);
    queue_random_packets(70);
    wait_for_quiet();

    program_settings(1, 17, 1'b1, 1'b0, 1'b0);
    queue_random_packets(70);
    wait_for_quiet();

    // No gaps from here on; the sender also stops once mid-phase until the
    // block has returned every predicted word.
    send_idle_pct = 0;
    program_settings(12, 31, 1'b0, 1'b0, 1'b1);
    queue_random_packets(45);
    wait_for_quiet();
    queue_random_packets(45);
    wait_for_quiet();

    running_number = 32'hFFFF_FFE0;
    program_settings(5, 8, 1'b1, 1'b1, 1'b0);
    queue_random_packets(100);
    wait_for_quiet();

    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
